### sv/spinor_pkg.sv
`timescale 1ns / 1ps

package spinor_pkg;

    // Item kinds carried in the input tuser field.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    // One input word, unpacked.
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  operation;
        logic [23:0] address;
        logic [8:0]  length;
        logic [7:0]  buffer_index;
        logic [7:0]  write_byte;
        logic        miso;
    } item_t;

    // One result word, as produced by the sequencer.
    typedef struct packed {
        logic       sck_pulse;
        logic       mosi;
        logic       cs_n;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       last;
        logic       busy_res;
    } result_t;

endpackage

### sv/spinor_pbuf.sv
`timescale 1ns / 1ps

module spinor_pbuf #(
    parameter int PAGE_BYTES = 256,
    localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [PAGE_BYTES];
    logic [7:0] rdata_reg;
    logic [7:0] byp_data_reg;
    logic       byp_reg;
    logic       byp_next;

    // Page buffer storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg    <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // A write to the entry being read in the same cycle is forwarded.
    assign byp_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rdata_reg;

endmodule

### sv/spinor_seq.sv
`timescale 1ns / 1ps

module spinor_seq
    import spinor_pkg::*;
#(
    parameter int PAGE_BYTES = 256,
    localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  item_t         item,
    input  logic [7:0]    page_data,
    output logic [AW-1:0] rd_addr,
    output result_t       res
);

    // Sequence steps; a gap step sits GAP_OFS above the step it leads to.
    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_RDID_CMD  = 5'd1;
    localparam logic [4:0] ST_RDID_DATA = 5'd2;
    localparam logic [4:0] ST_READ_HDR  = 5'd3;
    localparam logic [4:0] ST_READ_DATA = 5'd4;
    localparam logic [4:0] ST_PP_WREN   = 5'd5;
    localparam logic [4:0] ST_PP_HDR    = 5'd6;
    localparam logic [4:0] ST_PP_DATA   = 5'd7;
    localparam logic [4:0] ST_PP_RDSR   = 5'd8;
    localparam logic [4:0] ST_PP_POLL   = 5'd9;
    localparam logic [4:0] ST_SE_WREN1  = 5'd10;
    localparam logic [4:0] ST_SE_WRSR   = 5'd11;
    localparam logic [4:0] ST_SE_RDSR1  = 5'd12;
    localparam logic [4:0] ST_SE_POLL1  = 5'd13;
    localparam logic [4:0] ST_SE_WREN2  = 5'd14;
    localparam logic [4:0] ST_SE_CMD    = 5'd15;
    localparam logic [4:0] ST_SE_RDSR2  = 5'd16;
    localparam logic [4:0] ST_SE_POLL2  = 5'd17;
    localparam logic [4:0] GAP_OFS      = 5'd14;
    localparam logic [4:0] ST_GAP_LO    = 5'd20;
    localparam logic [4:0] ST_GAP_PP_HDR  = ST_PP_HDR + GAP_OFS;
    localparam logic [4:0] ST_GAP_PP_RDSR = ST_PP_RDSR + GAP_OFS;
    localparam logic [4:0] ST_GAP_SE_WRSR = ST_SE_WRSR + GAP_OFS;
    localparam logic [4:0] ST_GAP_SE_RDSR1 = ST_SE_RDSR1 + GAP_OFS;
    localparam logic [4:0] ST_GAP_SE_WREN2 = ST_SE_WREN2 + GAP_OFS;
    localparam logic [4:0] ST_GAP_SE_CMD  = ST_SE_CMD + GAP_OFS;
    localparam logic [4:0] ST_GAP_SE_RDSR2 = ST_SE_RDSR2 + GAP_OFS;

    // Flash command opcodes and fill bytes.
    localparam logic [7:0] CMD_RDID  = 8'h9F;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_SE    = 8'h20;
    localparam logic [7:0] CMD_WRSR  = 8'h01;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_FILL = 8'hFF;

    localparam logic [1:0] OP_READ_ID = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_PROGRAM = 2'd2;
    localparam logic [1:0] OP_ERASE   = 2'd3;

    logic [4:0]    step_reg,  step_next;
    logic [2:0]    bit_reg,   bit_next;
    logic [8:0]    byte_reg,  byte_next;
    logic [7:0]    so_reg,    so_next;
    logic [7:0]    si_reg,    si_next;
    logic [23:0]   addr_reg,  addr_next;
    logic [8:0]    total_reg, total_next;
    logic [AW-1:0] pidx_reg,  pidx_next;

    // Address byte of the command header for header byte number n.
    function automatic logic [7:0] addr_byte(input logic [23:0] a, input logic [8:0] n);
        logic [7:0] b;
        b = BYTE_ZERO;
        if (n == 9'd1)
        begin
            b = a[23:16];
        end
        else if (n == 9'd2)
        begin
            b = a[15:8];
        end
        else if (n == 9'd3)
        begin
            b = a[7:0];
        end
        return b;
    endfunction

    // Next-state and result logic for one word.
    always_comb
    begin
        logic [7:0]    tx_byte;
        logic [7:0]    si_new;
        logic [8:0]    n;
        logic [AW-1:0] pidx_inc;
        logic          counted;
        logic          go_en;
        logic [4:0]    go_step;
        logic          done;

        step_next  = step_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        so_next    = so_reg;
        si_next    = si_reg;
        addr_next  = addr_reg;
        total_next = total_reg;
        pidx_next  = pidx_reg;
        res        = '0;
        res.cs_n   = 1'b1;

        tx_byte  = so_reg;
        si_new   = {si_reg[6:0], item.miso};
        n        = byte_reg;
        counted  = 1'b0;
        go_en    = 1'b0;
        go_step  = ST_IDLE;
        done     = 1'b0;
        pidx_inc = (pidx_reg == AW'(PAGE_BYTES - 1)) ? '0 : pidx_reg + 1'b1;

        if (item.kind == KIND_TICK)
        begin
            if (step_reg >= ST_GAP_LO)
            begin
                // Chip select high for one tick between two commands.
                go_en        = 1'b1;
                go_step      = step_reg - GAP_OFS;
                res.busy_res = 1'b1;
            end
            else if (step_reg >= ST_RDID_CMD && step_reg <= ST_SE_POLL2)
            begin
                // Pick the byte to send at the first bit of each byte.
                if (bit_reg == 3'd0)
                begin
                    unique case (step_reg)
                        ST_RDID_CMD: tx_byte = CMD_RDID;
                        ST_READ_HDR:
                            tx_byte = (byte_reg == 9'd0) ? CMD_READ
                                                         : addr_byte(addr_reg, byte_reg);
                        ST_PP_WREN, ST_SE_WREN1, ST_SE_WREN2: tx_byte = CMD_WREN;
                        ST_PP_HDR:
                            tx_byte = (byte_reg == 9'd0) ? CMD_PP
                                                         : addr_byte(addr_reg, byte_reg);
                        ST_PP_DATA: tx_byte = page_data;
                        ST_PP_RDSR, ST_SE_RDSR1, ST_SE_RDSR2: tx_byte = CMD_RDSR;
                        ST_SE_WRSR: tx_byte = (byte_reg == 9'd0) ? CMD_WRSR : BYTE_ZERO;
                        ST_SE_CMD:
                            tx_byte = (byte_reg == 9'd0) ? CMD_SE
                                                         : addr_byte(addr_reg, byte_reg);
                        default: tx_byte = BYTE_FILL;
                    endcase
                end

                res.sck_pulse = 1'b1;
                res.cs_n      = 1'b0;
                res.mosi      = tx_byte[7];
                res.busy_res  = 1'b1;
                so_next       = {tx_byte[6:0], 1'b0};
                si_next       = si_new;
                bit_next      = bit_reg + 3'd1;

                // Byte boundary: emit captured data and advance the sequence.
                if (bit_reg == 3'd7)
                begin
                    if (step_reg == ST_RDID_DATA || step_reg == ST_READ_DATA)
                    begin
                        res.read_byte  = si_new;
                        res.read_valid = 1'b1;
                    end
                    counted = !(step_reg == ST_PP_POLL || step_reg == ST_SE_POLL1
                                || step_reg == ST_SE_POLL2);
                    if (counted)
                    begin
                        n         = byte_reg + 9'd1;
                        byte_next = n;
                        pidx_next = pidx_inc;
                    end

                    unique case (step_reg)
                        ST_RDID_CMD:
                            if (n >= 9'd1)
                            begin
                                go_en = 1'b1; go_step = ST_RDID_DATA;
                            end
                        ST_RDID_DATA:
                            done = (n >= 9'd3);
                        ST_READ_HDR:
                            if (n >= 9'd4)
                            begin
                                if (total_reg == 9'd0)
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    go_en = 1'b1; go_step = ST_READ_DATA;
                                end
                            end
                        ST_READ_DATA:
                            done = (n >= total_reg);
                        ST_PP_WREN:
                            if (n >= 9'd1)
                            begin
                                go_en = 1'b1; go_step = ST_GAP_PP_HDR;
                            end
                        ST_PP_HDR:
                            if (n >= 9'd4)
                            begin
                                go_en   = 1'b1;
                                go_step = (total_reg == 9'd0) ? ST_GAP_PP_RDSR : ST_PP_DATA;
                            end
                        ST_PP_DATA:
                            if (n >= total_reg)
                            begin
                                go_en = 1'b1; go_step = ST_GAP_PP_RDSR;
                            end
                        ST_PP_RDSR:
                        begin
                            go_en = 1'b1; go_step = ST_PP_POLL;
                        end
                        ST_PP_POLL, ST_SE_POLL2:
                            done = !si_new[0];
                        ST_SE_WREN1:
                        begin
                            go_en = 1'b1; go_step = ST_GAP_SE_WRSR;
                        end
                        ST_SE_WRSR:
                            if (n >= 9'd3)
                            begin
                                go_en = 1'b1; go_step = ST_GAP_SE_RDSR1;
                            end
                        ST_SE_RDSR1:
                        begin
                            go_en = 1'b1; go_step = ST_SE_POLL1;
                        end
                        ST_SE_POLL1:
                            if (!si_new[0])
                            begin
                                go_en = 1'b1; go_step = ST_GAP_SE_WREN2;
                            end
                        ST_SE_WREN2:
                        begin
                            go_en = 1'b1; go_step = ST_GAP_SE_CMD;
                        end
                        ST_SE_CMD:
                            if (n >= 9'd4)
                            begin
                                go_en = 1'b1; go_step = ST_GAP_SE_RDSR2;
                            end
                        ST_SE_RDSR2:
                        begin
                            go_en = 1'b1; go_step = ST_SE_POLL2;
                        end
                        default: ;
                    endcase

                    if (done)
                    begin
                        go_en    = 1'b1;
                        go_step  = ST_IDLE;
                        res.last = 1'b1;
                    end
                end
            end
            else
            begin
                go_en   = 1'b1;
                go_step = ST_IDLE;
            end
        end
        else
        begin
            // Start an operation; it is ignored while one is running.
            if (item.kind == KIND_START && step_reg == ST_IDLE)
            begin
                addr_next  = item.address;
                total_next = item.length;
                si_next    = 8'h00;
                so_next    = 8'h00;
                go_en      = 1'b1;
                unique case (item.operation)
                    OP_READ_ID: go_step = ST_RDID_CMD;
                    OP_READ:    go_step = ST_READ_HDR;
                    OP_PROGRAM: go_step = ST_PP_WREN;
                    OP_ERASE:   go_step = ST_SE_WREN1;
                    default:    go_step = ST_RDID_CMD;
                endcase
            end
        end

        if (go_en)
        begin
            step_next = go_step;
            bit_next  = 3'd0;
            byte_next = 9'd0;
            pidx_next = '0;
        end

        // Non-tick words show the held chip select level.
        if (item.kind != KIND_TICK)
        begin
            res.cs_n = !(step_next >= ST_RDID_CMD && step_next <= ST_SE_POLL2
                         && (bit_next != 3'd0 || byte_next != 9'd0));
            res.busy_res = (step_next != ST_IDLE);
        end
    end

    // The page buffer is read at the index the next word will need.
    assign rd_addr = accept ? pidx_next : pidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            bit_reg   <= 3'd0;
            byte_reg  <= 9'd0;
            so_reg    <= 8'h00;
            si_reg    <= 8'h00;
            addr_reg  <= 24'd0;
            total_reg <= 9'd0;
            pidx_reg  <= '0;
        end
        else if (accept)
        begin
            step_reg  <= step_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            so_reg    <= so_next;
            si_reg    <= si_next;
            addr_reg  <= addr_next;
            total_reg <= total_next;
            pidx_reg  <= pidx_next;
        end
    end

endmodule

### sv/spi_nor_flash_command_sequencer.sv
`timescale 1ns / 1ps

// SPI mode 0 NOR flash command sequencer, driven one serial bit per word.
// Input stream (s_axis): tuser carries the word kind: a bit tick, a start of
// an operation (read ID, read, page program, sector erase) or a page buffer
// load. tdata carries operation, address, length, buffer index, load byte
// and the sampled MISO bit.
// Output stream (m_axis): exactly one word per input word, carrying the SCK
// pulse, MOSI and CS_N levels for that tick, a captured byte with its valid
// flag in tuser, and the busy flag; tlast marks the tick ending an operation.
// Each result is registered in the output register on acceptance, and one
// word is taken every cycle while the output is not stalled. The page buffer
// is a synchronous memory with one write and one read port, read ahead at the
// index the next word may need; a load to that same entry is forwarded, so
// loads may be interleaved with ticks of a program.
// Reset returns the sequencer to idle and empties the output register; page
// buffer contents are undefined until loaded. When the receiver stalls, the
// result is held and s_axis_tready drops until it is taken.
module spi_nor_flash_command_sequencer
    import spinor_pkg::*;
#(
    parameter int PAGE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], address[25:2], length[34:26], buffer_index[42:35],
    // write_byte[50:43], miso[51], zero fill above
    input  logic [55:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sck_pulse[0], mosi[1], cs_n[2], read_byte[10:3], busy_res[11], zero fill above
    output logic [15:0] m_axis_tdata,
    // read_valid[0]
    output logic        m_axis_tuser,
    // last
    output logic        m_axis_tlast
);

    localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

    item_t         item;
    result_t       res;
    result_t       res_reg;
    logic          m_valid_reg, m_valid_next;
    logic          accept;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    page_data;

    // Unpack the input word.
    always_comb
    begin
        item.kind         = s_axis_tuser;
        item.operation    = s_axis_tdata[1:0];
        item.address      = s_axis_tdata[25:2];
        item.length       = s_axis_tdata[34:26];
        item.buffer_index = s_axis_tdata[42:35];
        item.write_byte   = s_axis_tdata[50:43];
        item.miso         = s_axis_tdata[51];
    end

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Loads beyond the page size are dropped.
    assign wr_en = accept && (item.kind == KIND_LOAD)
                   && (32'(item.buffer_index) < PAGE_BYTES);

    spinor_pbuf #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_pbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (AW'(item.buffer_index)),
        .wr_data (item.write_byte),
        .rd_addr (rd_addr),
        .rd_data (page_data)
    );

    spinor_seq #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .page_data (page_data),
        .rd_addr   (rd_addr),
        .res       (res)
    );

    // Output register.
    assign m_valid_next = accept || (m_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, res_reg.busy_res, res_reg.read_byte,
                            res_reg.cs_n, res_reg.mosi, res_reg.sck_pulse};
    assign m_axis_tuser  = res_reg.read_valid;
    assign m_axis_tlast  = res_reg.last;

endmodule
